// ===== rtl/rrfr_pkg.sv =====
// rrfr_pkg: types, byte codes and the code decoder of the reply frame receiver
// no dependencies

package rrfr_pkg;

  localparam int unsigned MAX_FRAME = 64;

  localparam logic [7:0] B_ACK = 8'h06;
  localparam logic [7:0] B_SYN = 8'h16;
  localparam logic [7:0] B_NAK = 8'h15;
  localparam logic [7:0] B_ETX = 8'h03;

  localparam logic [6:0] MIN_ID_LENGTH_RST = 7'd12;
  localparam logic [6:0] ID_FIRST_POS      = 7'd6;
  localparam logic [6:0] ID_BYTES          = 7'd8;
  localparam logic [6:0] CODE_HI_POS       = 7'd6;
  localparam logic [6:0] CODE_LO_POS       = 7'd7;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_ACK_BODY,
    PH_ACK_CHECK,
    PH_SYN_BODY,
    PH_SYN_CHECK
  } phase_t;

  typedef enum logic [2:0] {
    ST_ID_VALID   = 3'd0,
    ST_SHORT      = 3'd1,
    ST_CHECKSUM   = 3'd2,
    ST_NAK        = 3'd3,
    ST_DEVICE_ERR = 3'd4,
    ST_LINK_ERR   = 3'd5
  } status_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [6:0]  frame_length;
    logic [63:0] tag_id;
    logic [6:0]  device_code;
  } result_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_sign(input logic [7:0] c);
    return (c == 8'h2B) || (c == 8'h2D);
  endfunction

  // two-character decimal decode: blanks, optional sign, digits; negative gives zero
  function automatic logic [6:0] decode_code(input logic [15:0] chars);
    logic [7:0] c0;
    logic [7:0] c1;
    logic [6:0] d0;
    logic [6:0] d1;
    logic [6:0] val;
    c0  = chars[15:8];
    c1  = chars[7:0];
    d0  = {3'd0, c0[3:0]};
    d1  = {3'd0, c1[3:0]};
    val = 7'd0;
    if (is_blank(c0)) begin
      if (is_digit(c1)) val = d1;
    end else if (is_sign(c0)) begin
      if (is_digit(c1) && c0 == 8'h2B) val = d1;
    end else if (is_digit(c0)) begin
      if (is_digit(c1)) val = 7'((d0 << 3) + (d0 << 1) + d1);
      else              val = d0;
    end
    return val;
  endfunction

endpackage

// ===== rtl/rrfr_if.sv =====
// rrfr_if: valid/ready channel interfaces for received bytes and reply results
// depends on rrfr_pkg

interface rrfr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       rx_fail;

  modport source (output valid, rx_byte, rx_fail, input ready);
  modport sink   (input valid, rx_byte, rx_fail, output ready);
endinterface

interface rrfr_res_if import rrfr_pkg::*;;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [6:0]  frame_length;
  logic [63:0] tag_id;
  logic [6:0]  device_code;

  modport source (output valid, status, frame_length, tag_id, device_code, input ready);
  modport sink   (input valid, status, frame_length, tag_id, device_code, output ready);
endinterface

// ===== rtl/reader_reply_frame_receiver.sv =====
// reader_reply_frame_receiver: reply frame parser with xor block check
// depends on rrfr_pkg and the channel interfaces in rrfr_if.sv
//
// usage
//   in_chan  : one received serial byte per transaction (rx_byte, rx_fail)
//   out_chan : one reply result per transaction (status, frame_length,
//              tag_id, device_code); most bytes give no result, the byte
//              closing a frame (checksum byte), a nak byte while hunting or a failed read
//              gives exactly one
//   cfg_we / cfg_wdata : min_id_length, written while the block is idle
// timing
//   a byte is registered at the input, parsed by one pass of logic against
//   the frame state and its result lands in the output register, or in the skid
//   register while the output register holds an unread result; one byte is taken every cycle
//   while in_chan.ready is high; the parse state advances once per cycle while the skid is empty
// stalls
//   the output register is backed by a one-entry skid register, so bytes keep
//   flowing while one result waits; only when both hold a result and the
//   input register holds a byte does in_chan.ready drop
// reset
//   synchronous, active low: back to hunting for a start byte, all
//   registers empty, min_id_length back to 12

module reader_reply_frame_receiver
  import rrfr_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  rrfr_rx_if.sink        in_chan,
  rrfr_res_if.source     out_chan,
  input  logic           cfg_we,
  input  logic [5:0]     cfg_wdata
);

  // configuration
  logic [5:0] min_id_length_r;

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_fail_r;

  // frame state
  phase_t      phase_r, phase_nxt;
  logic [6:0]  byte_count_r, byte_count_nxt;
  logic [7:0]  running_xor_r, running_xor_nxt;
  logic        zero_seen_r, zero_seen_nxt;
  logic [63:0] id_bytes_r, id_bytes_nxt;
  logic [15:0] code_chars_r, code_chars_nxt;

  // result registers: output stage and skid
  logic    o_valid_r;
  result_t o_res_r;
  logic    k_valid_r;
  result_t k_res_r;

  logic    s1_fire;
  logic    in_fire;
  logic    pop;
  logic    push;
  result_t push_res;
  logic    zero_now;

  assign in_chan.ready = !s1_valid_r || !k_valid_r;
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign s1_fire       = s1_valid_r && !k_valid_r;
  assign pop           = o_valid_r && out_chan.ready;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_id_length_r <= MIN_ID_LENGTH_RST[5:0];
    end else if (cfg_we) begin
      min_id_length_r <= cfg_wdata;
    end
  end

  // input register: holds while the skid is full
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_chan.rx_byte;
      s1_fail_r <= in_chan.rx_fail;
    end
  end

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (s1_fail_r) begin
      phase_nxt = PH_HUNT;
    end else begin
      unique case (phase_r)
        PH_HUNT: begin
          if (s1_byte_r == B_ACK)      phase_nxt = PH_ACK_BODY;
          else if (s1_byte_r == B_SYN) phase_nxt = PH_SYN_BODY;
        end
        PH_ACK_BODY: begin
          if (s1_byte_r == B_ETX) phase_nxt = PH_ACK_CHECK;
        end
        PH_SYN_BODY: begin
          if (s1_byte_r == B_ETX) phase_nxt = PH_SYN_CHECK;
        end
        PH_ACK_CHECK, PH_SYN_CHECK: begin
          phase_nxt = PH_HUNT;
        end
        default: phase_nxt = PH_HUNT;
      endcase
    end
  end

  // frame datapath and result
  assign zero_now = (s1_byte_r == 8'h00);

  always_comb begin
    byte_count_nxt  = byte_count_r;
    running_xor_nxt = running_xor_r;
    zero_seen_nxt   = zero_seen_r;
    id_bytes_nxt    = id_bytes_r;
    code_chars_nxt  = code_chars_r;
    push            = 1'b0;
    push_res        = '0;

    if (s1_fail_r) begin
      push            = 1'b1;
      push_res.status = ST_LINK_ERR;
    end else begin
      unique case (phase_r)
        PH_HUNT: begin
          if (s1_byte_r == B_ACK || s1_byte_r == B_SYN) begin
            // start of a frame
            byte_count_nxt  = 7'd1;
            running_xor_nxt = s1_byte_r;
            zero_seen_nxt   = 1'b0;
            id_bytes_nxt    = '0;
            code_chars_nxt  = '0;
          end else if (s1_byte_r == B_NAK) begin
            push                  = 1'b1;
            push_res.status       = ST_NAK;
            push_res.frame_length = 7'd1;
          end
        end
        PH_ACK_BODY, PH_SYN_BODY: begin
          // xor covers bytes up to the first zero byte
          zero_seen_nxt = zero_seen_r || zero_now;
          if (!zero_seen_r && !zero_now) begin
            running_xor_nxt = running_xor_r ^ s1_byte_r;
          end
          for (int k = 0; k < 8; k++) begin
            if (byte_count_r == ID_FIRST_POS + 7'(k)) begin
              id_bytes_nxt[63 - 8*k -: 8] = s1_byte_r;
            end
          end
          if (byte_count_r == CODE_HI_POS) code_chars_nxt[15:8] = s1_byte_r;
          if (byte_count_r == CODE_LO_POS) code_chars_nxt[7:0]  = s1_byte_r;
          if (byte_count_r < 7'(MAX_FRAME)) begin
            byte_count_nxt = byte_count_r + 7'd1;
          end
        end
        PH_ACK_CHECK: begin
          push                  = 1'b1;
          push_res.frame_length = byte_count_r;
          if (byte_count_r <= {1'b0, min_id_length_r}) begin
            push_res.status = ST_SHORT;
          end else if (s1_byte_r == running_xor_r) begin
            push_res.status = ST_ID_VALID;
            push_res.tag_id = id_bytes_r;
          end else begin
            push_res.status = ST_CHECKSUM;
          end
        end
        PH_SYN_CHECK: begin
          push                  = 1'b1;
          push_res.status       = ST_DEVICE_ERR;
          push_res.frame_length = byte_count_r;
          push_res.device_code  = decode_code(code_chars_r);
        end
        default: begin
        end
      endcase
    end
  end

  // frame state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_HUNT;
      byte_count_r  <= '0;
      running_xor_r <= '0;
      zero_seen_r   <= 1'b0;
    end else if (s1_fire) begin
      phase_r       <= phase_nxt;
      byte_count_r  <= byte_count_nxt;
      running_xor_r <= running_xor_nxt;
      zero_seen_r   <= zero_seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      id_bytes_r   <= id_bytes_nxt;
      code_chars_r <= code_chars_nxt;
    end
  end

  // output register with skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
      k_valid_r <= 1'b0;
    end else if (k_valid_r) begin
      if (pop) begin
        o_valid_r <= 1'b1;
        k_valid_r <= 1'b0;
      end
    end else if (o_valid_r && !pop) begin
      if (s1_fire && push) k_valid_r <= 1'b1;
    end else begin
      o_valid_r <= s1_fire && push;
    end
  end

  always_ff @(posedge clk) begin
    if (k_valid_r) begin
      if (pop) o_res_r <= k_res_r;
    end else if (o_valid_r && !pop) begin
      if (s1_fire && push) k_res_r <= push_res;
    end else if (s1_fire && push) begin
      o_res_r <= push_res;
    end
  end

  assign out_chan.valid        = o_valid_r;
  assign out_chan.status       = o_res_r.status;
  assign out_chan.frame_length = o_res_r.frame_length;
  assign out_chan.tag_id       = o_res_r.tag_id;
  assign out_chan.device_code  = o_res_r.device_code;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    k_valid_r |-> o_valid_r)
    else $error("skid holds a result while the output register is empty");

  a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> (s1_valid_r && k_valid_r))
    else $error("input stalled with room downstream");

  a_check_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && (phase_r == PH_ACK_CHECK || phase_r == PH_SYN_CHECK)) |=> phase_r == PH_HUNT)
    else $error("checksum byte did not end the frame");

  a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
    byte_count_r <= 7'(MAX_FRAME))
    else $error("frame byte count past saturation");

  a_link_err_len: assert property (@(posedge clk) disable iff (!rst_n)
    (o_valid_r && o_res_r.status == ST_LINK_ERR) |->
      (o_res_r.frame_length == 7'd0 && o_res_r.tag_id == 64'd0))
    else $error("link error result carries frame data");
`endif

endmodule

// ===== bench/tb_reader_reply_frame_receiver.sv =====
// tb_reader_reply_frame_receiver: self-checking bench for the reply frame receiver
// depends on rtl/rrfr_pkg.sv, rtl/rrfr_if.sv and rtl/reader_reply_frame_receiver.sv
// byte-level frame tracker predicts each reply; directed frames first, then paced random traffic

module tb_reader_reply_frame_receiver import rrfr_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // pacing and run length
  localparam int RANDOM_BYTES = 1250;
  localparam int SETTLE_CYCLES = 8;      // margin for a result to pass the input and output registers and the skid
  localparam int STALL_LIMIT = 4000;     // cycles with no transaction on either channel
  localparam int ID_LAST = int'(ID_FIRST_POS) + int'(ID_BYTES) - 1;

  // ascii characters used by the device code decoder
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [5:0] cfg_wdata;

  rrfr_rx_if in_if ();
  rrfr_res_if out_if ();

  reader_reply_frame_receiver u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // frame tracker: mirrors the receiver one accepted byte at a time
  // ---------------------------------------------------------------------------
  phase_t rx_phase;
  logic [6:0] frame_count;     // saturates at MAX_FRAME
  logic [7:0] block_xor;       // xor from the start byte up to the first zero byte
  logic past_zero;
  logic [63:0] id_shift;
  logic [15:0] code_pair;      // offset 6 in the high byte
  logic [5:0] min_len_cfg;

  result_t awaited_replies[$];

  // pacing knobs, in percent; link failures in per mille
  int sender_idle_pct;
  int recv_stall_pct;
  int fail_permille;

  int bytes_sent;
  int replies_checked;
  int cfg_writes;
  int mismatches;
  int status_hits[6];
  int idle_cycles;

  // atoi on two characters: blanks, optional sign, digits; negative reads as zero
  function automatic logic [6:0] ascii_code_value(input logic [15:0] pair);
    logic [7:0] ch[2];
    int k;
    int val;
    bit neg;
    ch[0] = pair[15:8];
    ch[1] = pair[7:0];
    k = 0;
    val = 0;
    neg = 1'b0;
    while (k < 2 && (ch[k] == CH_SPACE || (ch[k] >= CH_TAB && ch[k] <= CH_CR)))
      k++;
    if (k < 2 && (ch[k] == CH_PLUS || ch[k] == CH_MINUS)) begin
      neg = (ch[k] == CH_MINUS);
      k++;
    end
    while (k < 2 && ch[k] >= CH_ZERO && ch[k] <= CH_NINE) begin
      val = val * 10 + int'(ch[k] - CH_ZERO);
      k++;
    end
    return neg ? 7'd0 : 7'(val);
  endfunction

  task automatic open_frame(input logic [7:0] b, input phase_t ph);
    rx_phase = ph;
    frame_count = 7'd1;
    block_xor = b;
    past_zero = 1'b0;
    id_shift = '0;
    code_pair = '0;
  endtask

  // works out the reply, if any, that one accepted byte causes
  task automatic predict_reply(input logic [7:0] b, input logic fail);
    result_t r;
    bit gives_reply;
    int pos;
    r = '0;
    gives_reply = 1'b0;
    if (fail) begin
      // a failed read drops whatever frame was open
      rx_phase = PH_HUNT;
      r.status = ST_LINK_ERR;
      gives_reply = 1'b1;
    end else begin
      case (rx_phase)
        PH_HUNT: begin
          if (b == B_ACK) begin
            open_frame(b, PH_ACK_BODY);
          end else if (b == B_SYN) begin
            open_frame(b, PH_SYN_BODY);
          end else if (b == B_NAK) begin
            r.status = ST_NAK;
            r.frame_length = 7'd1;
            gives_reply = 1'b1;
          end
        end
        PH_ACK_BODY, PH_SYN_BODY: begin
          pos = int'(frame_count);
          if (b == 8'h00) past_zero = 1'b1;
          if (!past_zero) block_xor ^= b;
          if (pos >= int'(ID_FIRST_POS) && pos <= ID_LAST)
            id_shift |= 64'(b) << (8 * (ID_LAST - pos));
          if (frame_count == CODE_HI_POS) code_pair[15:8] = b;
          else if (frame_count == CODE_LO_POS) code_pair[7:0] = b;
          if (int'(frame_count) < MAX_FRAME) frame_count++;
          if (b == B_ETX)
            rx_phase = (rx_phase == PH_ACK_BODY) ? PH_ACK_CHECK : PH_SYN_CHECK;
        end
        PH_ACK_CHECK: begin
          rx_phase = PH_HUNT;
          r.frame_length = frame_count;
          gives_reply = 1'b1;
          // a short frame never gets its block check compared
          if (frame_count <= {1'b0, min_len_cfg}) begin
            r.status = ST_SHORT;
          end else if (b == block_xor) begin
            r.status = ST_ID_VALID;
            r.tag_id = id_shift;
          end else begin
            r.status = ST_CHECKSUM;
          end
        end
        PH_SYN_CHECK: begin
          // block check byte of a syn frame is taken but not compared
          rx_phase = PH_HUNT;
          r.status = ST_DEVICE_ERR;
          r.frame_length = frame_count;
          r.device_code = ascii_code_value(code_pair);
          gives_reply = 1'b1;
        end
        default: rx_phase = PH_HUNT;
      endcase
    end
    if (gives_reply) awaited_replies.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // result side: random back-pressure and in-order field compare
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    out_if.ready = ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : reply_check
    result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (awaited_replies.size() == 0) begin
        $display("%0t ns: unexpected reply, expected none, actual status %0d length %0d",
                 $time, out_if.status, out_if.frame_length);
        mismatches++;
      end else begin
        want = awaited_replies.pop_front();
        check_field("status", 64'(want.status), 64'(out_if.status));
        check_field("frame_length", 64'(want.frame_length), 64'(out_if.frame_length));
        check_field("tag_id", want.tag_id, out_if.tag_id);
        check_field("device_code", 64'(want.device_code), 64'(out_if.device_code));
        if (want.status < 6) status_hits[want.status]++;
      end
      replies_checked++;
    end
  end

  // watchdog on cycles where neither channel moves a transaction
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t ns: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // byte side
  // ---------------------------------------------------------------------------

  // one byte transaction; random idle cycles ahead of it, random link failure on top
  task automatic send_byte(input logic [7:0] b, input logic fail = 1'b0);
    logic f;
    f = fail || ($urandom_range(999) < fail_permille);
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk);
      in_if.valid = 1'b0;
      in_if.rx_byte = 8'($urandom);
      in_if.rx_fail = 1'($urandom);
    end
    @(negedge clk);
    in_if.valid = 1'b1;
    in_if.rx_byte = b;
    in_if.rx_fail = f;
    do @(posedge clk); while (!in_if.ready);
    predict_reply(b, f);
    bytes_sent++;
  endtask

  // drop valid and let every awaited reply arrive, then let the pipe empty
  task automatic wait_all_replies();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_min_length(input logic [5:0] v);
    wait_all_replies();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(posedge clk);
    min_len_cfg = v;
    cfg_writes++;
    @(negedge clk);
    cfg_we = 1'b0;
    cfg_wdata = 6'($urandom);
  endtask

  // frame body byte: never etx and never zero, those are placed on purpose
  function automatic logic [7:0] body_byte();
    logic [7:0] b;
    b = 8'($urandom);
    if (b == B_ETX) b = 8'h83;
    if (b == 8'h00) b = 8'h80;
    return b;
  endfunction

  function automatic logic [7:0] code_char();
    int pick;
    pick = $urandom_range(99);
    if (pick < 45) return CH_ZERO + 8'($urandom_range(9));
    else if (pick < 55) return CH_SPACE;
    else if (pick < 62) return 8'($urandom_range(int'(CH_TAB), int'(CH_CR)));
    else if (pick < 72) return CH_PLUS;
    else if (pick < 80) return CH_MINUS;
    else if (pick < 88) return 8'h00;
    else return 8'($urandom);
  endfunction

  // ack, body, etx, block check; zero_at puts a zero byte at that body offset
  task automatic send_ack_frame(input int body_len, input bit good_sum, input int zero_at = -1);
    logic [7:0] b;
    logic [7:0] sum;
    bit hit_zero;
    sum = B_ACK;
    hit_zero = 1'b0;
    send_byte(B_ACK);
    for (int i = 1; i <= body_len; i++) begin
      b = (i == zero_at) ? 8'h00 : body_byte();
      if (b == 8'h00) hit_zero = 1'b1;
      if (!hit_zero) sum ^= b;
      send_byte(b);
    end
    if (!hit_zero) sum ^= B_ETX;
    send_byte(B_ETX);
    send_byte(good_sum ? sum : sum ^ 8'($urandom_range(1, 255)));
  endtask

  // syn, body with the two code characters at offsets 6 and 7, etx, unchecked byte
  task automatic send_syn_frame(input int body_len, input logic [7:0] hi, input logic [7:0] lo);
    send_byte(B_SYN);
    for (int i = 1; i <= body_len; i++) begin
      if (i == int'(CODE_HI_POS)) send_byte(hi);
      else if (i == int'(CODE_LO_POS)) send_byte(lo);
      else send_byte(body_byte());
    end
    send_byte(B_ETX);
    send_byte(8'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset threshold of 12: valid id, short reply on the boundary, bad check, zero byte
  task automatic test_ack_frames();
    send_ack_frame(11, 1'b1);          // 13 bytes, just over the threshold
    send_ack_frame(10, 1'b1);          // 12 bytes, short
    send_ack_frame(10, 1'b0);          // short, check not compared
    send_ack_frame(14, 1'b0);          // checksum error
    send_ack_frame(14, 1'b1, 3);       // xor stops at the zero byte
    send_ack_frame(12, 1'b1, 1);       // zero straight after ack
    send_ack_frame(70, 1'b1);          // length saturates, xor runs on
  endtask

  // stray bytes are dropped while hunting, nak answers at once
  task automatic test_nak_and_noise();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(B_ETX);
    send_byte(B_NAK);
    send_byte(B_NAK);
    send_byte(8'h7F);
  endtask

  // read failure while hunting, inside a frame and on the block check byte
  task automatic test_link_errors();
    send_byte(8'hFF, 1'b1);
    send_byte(B_ACK);
    repeat (5) send_byte(body_byte());
    send_byte(8'h00, 1'b1);
    send_byte(B_ACK);
    repeat (12) send_byte(body_byte());
    send_byte(B_ETX);
    send_byte(8'h5A, 1'b1);
    send_byte(B_SYN);
    repeat (3) send_byte(body_byte());
    send_byte(B_ETX, 1'b1);
    send_byte(B_NAK, 1'b1);            // failure wins over a nak byte
  endtask

  // decimal device codes: digits, blanks, signs, stray chars, missing chars
  task automatic test_device_codes();
    send_syn_frame(7, 8'h34, 8'h32);   // "42"
    send_syn_frame(7, CH_SPACE, 8'h37);
    send_syn_frame(7, CH_MINUS, 8'h35);
    send_syn_frame(7, CH_PLUS, 8'h39);
    send_syn_frame(7, 8'h39, 8'h78);   // digit then letter
    send_syn_frame(7, 8'h00, 8'h31);
    send_syn_frame(7, CH_TAB, CH_MINUS);
    send_syn_frame(9, CH_NINE, CH_NINE);
    send_syn_frame(6, 8'h38, 8'h00);   // etx lands at offset 7
    send_syn_frame(3, 8'h00, 8'h00);   // code bytes never arrive
  endtask

  // threshold extremes, including partial id and saturated length at the top
  task automatic test_threshold_extremes();
    write_min_length(6'd0);
    send_ack_frame(0, 1'b1);           // ack and etx only
    send_ack_frame(6, 1'b1);           // id bytes partly received
    write_min_length(6'd63);
    send_ack_frame(61, 1'b1);          // 63 bytes, still short
    send_ack_frame(62, 1'b1);          // 64 bytes, saturated and valid
    send_ack_frame(75, 1'b0);
    write_min_length(MIN_ID_LENGTH_RST[5:0]);
  endtask

  // sender holds back until every reply is in, with the receiver stalling
  task automatic test_pause_for_replies();
    recv_stall_pct = 81;
    send_ack_frame(12, 1'b1);
    send_byte(B_NAK);
    send_syn_frame(8, 8'h31, 8'h35);
    wait_all_replies();
    send_ack_frame(13, 1'b1);
    recv_stall_pct = 0;
  endtask

  // mostly well-formed frames with random content, some noise and broken frames
  task automatic random_frame_group();
    int pick;
    int body;
    pick = $urandom_range(99);
    if (pick < 45) begin
      body = ($urandom_range(9) == 0) ? $urandom_range(40, 75) : $urandom_range(0, 20);
      if (body > 0 && $urandom_range(4) == 0)
        send_ack_frame(body, $urandom_range(3) != 0, $urandom_range(1, body));
      else
        send_ack_frame(body, $urandom_range(3) != 0);
    end else if (pick < 65) begin
      send_syn_frame($urandom_range(0, 12), code_char(), code_char());
    end else if (pick < 75) begin
      send_byte(B_NAK);
    end else if (pick < 88) begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
    end else begin
      // frame cut short by a failed read
      send_byte($urandom_range(1) ? B_ACK : B_SYN);
      repeat ($urandom_range(0, 15)) send_byte(body_byte());
      send_byte(8'($urandom), 1'b1);
    end
  endtask

  // four pacing phases: none, idle sender, stalling receiver, both lightly
  task automatic test_random_traffic();
    int idle_pct[4];
    int stall_pct[4];
    int phase_end;
    idle_pct = '{0, 81, 0, 19};
    stall_pct = '{0, 0, 81, 19};
    fail_permille = 10;
    for (int p = 0; p < 4; p++) begin
      write_min_length(6'($urandom_range(0, 16)));
      sender_idle_pct = idle_pct[p];
      recv_stall_pct = stall_pct[p];
      phase_end = bytes_sent + RANDOM_BYTES / 4;
      while (bytes_sent < phase_end) random_frame_group();
    end
    fail_permille = 0;
    sender_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_if.valid = 1'b0;
    in_if.rx_byte = '0;
    in_if.rx_fail = 1'b0;
    out_if.ready = 1'b0;
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    fail_permille = 0;
    bytes_sent = 0;
    replies_checked = 0;
    cfg_writes = 0;
    mismatches = 0;
    idle_cycles = 0;
    foreach (status_hits[i]) status_hits[i] = 0;

    // tracker comes out of reset hunting, threshold at its reset value
    rx_phase = PH_HUNT;
    frame_count = '0;
    block_xor = '0;
    past_zero = 1'b0;
    id_shift = '0;
    code_pair = '0;
    min_len_cfg = MIN_ID_LENGTH_RST[5:0];

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_ack_frames();
    test_nak_and_noise();
    test_link_errors();
    test_device_codes();
    test_threshold_extremes();
    test_pause_for_replies();
    test_random_traffic();

    wait_all_replies();
    if (awaited_replies.size() != 0) begin
      $display("%0t ns: %0d replies never arrived", $time, awaited_replies.size());
      mismatches++;
    end

    $display("run covered %0d received bytes, %0d replies checked, %0d threshold writes",
             bytes_sent, replies_checked, cfg_writes);
    $display("reply mix: id %0d, short %0d, checksum %0d, nak %0d, device %0d, link %0d",
             status_hits[0], status_hits[1], status_hits[2], status_hits[3],
             status_hits[4], status_hits[5]);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
